// ----- rtl/mrpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_pkg: shared types and constants for the Miller-Rabin prime test
// Base table, default widths and sequencer state encoding.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int BASE_COUNT_DEF = 7;
  localparam int BASE_TABLE_LEN = 12;
  localparam int BASE_IDX_BITS  = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_BASE,
    ST_POW_BIT,
    ST_POW_SQ,
    ST_POW_WAIT,
    ST_CHECK,
    ST_SQ,
    ST_SQ_WAIT,
    ST_DONE
  } mrpt_state_t;

  function automatic logic [5:0] base_of(input logic [BASE_IDX_BITS-1:0] idx);
    logic [5:0] b;
    unique case (idx)
      4'd0:    b = 6'd2;
      4'd1:    b = 6'd3;
      4'd2:    b = 6'd5;
      4'd3:    b = 6'd7;
      4'd4:    b = 6'd11;
      4'd5:    b = 6'd13;
      4'd6:    b = 6'd17;
      4'd7:    b = 6'd19;
      4'd8:    b = 6'd23;
      4'd9:    b = 6'd29;
      4'd10:   b = 6'd31;
      4'd11:   b = 6'd37;
      default: b = 6'd37;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/mrpt_mulmod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_mulmod: bit-serial shift-add modular multiplier
// One bit of y per cycle, MSB first: acc = 2*acc (+x) mod m, operands below m.
// ----------------------------------------------------------------------------
module mrpt_mulmod #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] result
);
  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [W-1:0]  acc;
  logic [W-1:0]  xr;
  logic [W-1:0]  yr;
  logic [W-1:0]  mr;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dbl;
  logic [W-1:0]  acc_next;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] mm);
    logic [W-1:0] gap;
    gap = mm - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

  always_comb begin
    dbl      = add_mod(acc, acc, mr);
    acc_next = yr[W-1] ? add_mod(dbl, xr, mr) : dbl;
  end

  assign result = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        acc  <= '0;
        xr   <= x;
        yr   <= y;
        mr   <= m;
      end else if (busy) begin
        acc <= acc_next;
        yr  <= {yr[W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/mrpt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_ctrl: Miller-Rabin sequencer
// Splits n-1, walks the bases, runs square-and-multiply and the squarings.
// ----------------------------------------------------------------------------
module mrpt_ctrl #(
  parameter int W          = 64,
  parameter int BASE_COUNT = 7
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [W-1:0] n_in,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] n_out,
  output logic         prime_out
);
  import mrpt_pkg::*;

  localparam int CNT = (BASE_COUNT < 1) ? 1 :
                       (BASE_COUNT > BASE_TABLE_LEN) ? BASE_TABLE_LEN : BASE_COUNT;
  localparam int RW  = $clog2(W + 1);

  mrpt_state_t state, state_next;

  logic [W-1:0]  n;
  logic [W-1:0]  nm1;
  logic [W-1:0]  d;
  logic [W-1:0]  ex;
  logic [W-1:0]  acc;
  logic [W-1:0]  sq;
  logic [RW-1:0] r;
  logic [RW-1:0] i;
  logic [BASE_IDX_BITS-1:0] k;
  logic          mul_start;
  logic [W-1:0]  mul_x;
  logic [W-1:0]  mul_y;
  logic          mul_done;
  logic [W-1:0]  mul_res;
  logic          pend_acc;
  logic [W-1:0]  base_w;
  logic          base_pass;

  assign base_w = W'(base_of(k));
  // a 1 counts only before the first squaring; n-1 counts at any point
  assign base_pass = (acc == W'(1) && i == RW'(1)) || acc == nm1;

  mrpt_mulmod #(.W(W)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .x(mul_x), .y(mul_y), .m(n),
    .done(mul_done), .result(mul_res)
  );

  assign in_stall = (state != ST_IDLE);
  assign n_out    = n;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_x      = acc;
    mul_y      = sq;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SPLIT;
      ST_SPLIT: begin
        if (n < W'(2) || n == W'(2) || !n[0]) state_next = ST_DONE;
        else if (!d[0]) state_next = ST_SPLIT;
        else state_next = ST_BASE;
      end
      ST_BASE: begin
        if (int'(k) >= CNT || base_w >= n) state_next = ST_DONE;
        else state_next = ST_POW_BIT;
      end
      ST_POW_BIT: begin
        if (ex == '0) state_next = ST_CHECK;
        else if (ex[0]) begin
          mul_start  = 1'b1;
          mul_x      = acc;
          mul_y      = sq;
          state_next = ST_POW_WAIT;
        end else state_next = ST_POW_SQ;
      end
      ST_POW_SQ: begin
        mul_start  = 1'b1;
        mul_x      = sq;
        mul_y      = sq;
        state_next = ST_POW_WAIT;
      end
      ST_POW_WAIT: if (mul_done) state_next = pend_acc ? ST_POW_SQ : ST_POW_BIT;
      ST_CHECK: begin
        if (base_pass) state_next = ST_BASE;
        else if (i >= r) state_next = ST_DONE;
        else begin
          mul_start  = 1'b1;
          mul_x      = acc;
          mul_y      = acc;
          state_next = ST_SQ_WAIT;
        end
      end
      ST_SQ:      state_next = ST_CHECK;
      ST_SQ_WAIT: if (mul_done) state_next = ST_SQ;
      ST_DONE:    if (!out_stall) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_next == ST_DONE);
      unique case (state)
        ST_IDLE: if (in_valid) begin
          n   <= n_in;
          nm1 <= n_in - 1'b1;
          d   <= n_in - 1'b1;
          r   <= '0;
          k   <= '0;
        end
        ST_SPLIT: begin
          if (!d[0]) begin
            d <= {1'b0, d[W-1:1]};
            r <= r + 1'b1;
          end
          prime_out <= (n >= W'(2)) && (n == W'(2) || n[0]);
        end
        ST_BASE: begin
          ex       <= d;
          acc      <= W'(1);
          sq       <= base_w;
          i        <= RW'(1);
          pend_acc <= 1'b0;
        end
        ST_POW_BIT: if (ex != '0 && ex[0]) pend_acc <= 1'b1;
        ST_POW_SQ: begin
          pend_acc <= 1'b0;
          ex       <= {1'b0, ex[W-1:1]};
        end
        ST_POW_WAIT: if (mul_done) begin
          if (pend_acc) acc <= mul_res;
          else sq <= mul_res;
        end
        ST_CHECK: begin
          if (base_pass) k <= k + 1'b1;
          else if (i >= r) prime_out <= 1'b0;
        end
        ST_SQ_WAIT: if (mul_done) begin
          acc <= mul_res;
          i   <= i + 1'b1;
        end
        ST_SQ: ;
        ST_DONE: ;
        default: ;
      endcase
    end
  end
endmodule

// ----- rtl/miller_rabin_prime_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_prime_test: 64-bit Miller-Rabin strong probable prime test
// Bases 2,3,5,7,11,13,17 with a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: candidate with in_valid / in_stall. One request is taken
//   while the block is idle; in_stall stays high until the result is taken.
//   Output channel: tested_value and is_prime with out_valid / out_stall;
//   the result holds while out_stall is high.
//   Work: each modular multiply is a full pass of the shift-add multiplier.
//   Per base one squaring per bit of d, one multiply per set bit of d and
//   up to r-1 further squarings; most composites stop after the first base,
//   and even values and values below 3 skip the bases. The serial
//   multiplier sets the rate.
//   Reset (rst, synchronous): returns to idle and drops any request in work.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test #(
  parameter int VALUE_BITS = mrpt_pkg::VALUE_BITS_DEF,
  parameter int BASE_COUNT = mrpt_pkg::BASE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] candidate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] tested_value,
  output logic        is_prime
);
  logic [VALUE_BITS-1:0] n_out;

  mrpt_ctrl #(.W(VALUE_BITS), .BASE_COUNT(BASE_COUNT)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .n_in(candidate[VALUE_BITS-1:0]),
    .out_valid(out_valid), .out_stall(out_stall), .n_out(n_out), .prime_out(is_prime)
  );

  assign tested_value = 64'(n_out);

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("result pending while accepting");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tested_value) && $stable(is_prime))
    else $error("result dropped under stall");
  a_even: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tested_value[0] && tested_value != 64'd2 |-> !is_prime)
    else $error("even value reported prime");
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for miller_rabin_prime_test
// Sends directed and random candidates over the valid/stall channel, predicts
// the strong-probable-prime verdict with wide modular arithmetic and checks
// every result in order, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import mrpt_pkg::*;

  localparam int          NUM_BASES   = BASE_COUNT_DEF;
  localparam longint      CYCLE_LIMIT = 40_000_000;
  localparam int          RAND_ITEMS  = 80;

  typedef struct {
    logic [63:0] value;
    logic        prime;
  } verdict_t;

  class prime_scoreboard;
    verdict_t    verdicts[$];
    int          mismatches;

    function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] m);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return 64'(prod % {64'd0, m});
    endfunction

    function automatic logic [63:0] pow_mod(logic [63:0] a, logic [63:0] e,
                                            logic [63:0] m);
      logic [63:0] acc;
      logic [63:0] sq;
      acc = 64'd1 % m;
      sq  = a % m;
      while (e != 0) begin
        if (e[0]) acc = mul_mod(acc, sq, m);
        sq = mul_mod(sq, sq, m);
        e  = e >> 1;
      end
      return acc;
    endfunction

    function automatic logic passes_bases(logic [63:0] n);
      logic [63:0] d;
      logic [63:0] x;
      logic [63:0] nm1;
      logic [5:0]  a;
      int          r;
      int          k;
      int          i;
      logic        found;
      if (n < 2) return 1'b0;
      if (n == 2) return 1'b1;
      if (!n[0]) return 1'b0;
      nm1 = n - 1;
      d   = nm1;
      r   = 0;
      while (!d[0]) begin
        d = d >> 1;
        r++;
      end
      for (k = 0; k < NUM_BASES; k++) begin
        a = base_of(BASE_IDX_BITS'(k));
        // stop at the first base that is not below n
        if (64'(a) >= n) break;
        x = pow_mod(64'(a), d, n);
        if (x == 1 || x == nm1) continue;
        found = 1'b0;
        for (i = 1; i < r && !found; i++) begin
          x = mul_mod(x, x, n);
          if (x == nm1) found = 1'b1;
        end
        if (!found) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(logic [63:0] cand);
      verdict_t v;
      v.value = cand;
      v.prime = passes_bases(cand);
      verdicts.insert(verdicts.size(), v);
    endfunction

    function void check_result(logic [63:0] value, logic prime);
      verdict_t v;
      if (verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value=%0d is_prime=%0b", value, prime);
        return;
      end
      v = verdicts.pop_front();
      if (value !== v.value || prime !== v.prime) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value=%0d is_prime=%0b, got value=%0d is_prime=%0b",
                   v.value, v.prime, value, prime);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] candidate = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] tested_value;
  logic        is_prime;
  longint      cycles = 0;
  logic        calm = 1'b0;
  prime_scoreboard sb = new();

  miller_rabin_prime_test dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .candidate(candidate),
    .out_valid(out_valid), .out_stall(out_stall),
    .tested_value(tested_value), .is_prime(is_prime)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("miller_rabin_prime_test regression: fail");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int gap_len();
    if (calm) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(10, 150);
  endfunction

  // take results and hold stall in random runs
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(tested_value, is_prime);
      if (hold > 0) begin
        hold--;
      end else begin
        hold = gap_len();
        out_stall <= (hold > 0);
      end
    end
  end

  task automatic send_request(logic [63:0] value);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    candidate <= value;
    do @(posedge clk); while (in_stall);
    sb.note_request(value);
  endtask

  function automatic logic [63:0] random_candidate();
    logic [63:0] v;
    int          w;
    v = {$urandom(), $urandom()};
    // keep most candidates narrow so the run stays short
    if ($urandom_range(0, 11) != 0) begin
      w = $urandom_range(2, 24);
      v = v & ((64'd1 << w) - 1);
    end
    if ($urandom_range(0, 3) != 0) v[0] = 1'b1;
    return v;
  endfunction

  initial begin
    logic [63:0] directed[$];
    directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd17, 64'd19,
                 64'd37, 64'd561, 64'd2047, 64'd1373653, 64'd25326001,
                 64'd3215031751, 64'd341550071728321, 64'd1000000007,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                 64'd18446744073709551557, 64'h8000_0000_0000_0001};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_request(directed[i]);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if ($urandom_range(0, 19) == 0) calm = ~calm;
      if (i == RAND_ITEMS / 2) begin
        // drain everything before sending on
        in_valid <= 1'b0;
        while (sb.verdicts.size() != 0) @(posedge clk);
      end
      send_request(random_candidate());
    end
    in_valid <= 1'b0;
    while (sb.verdicts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0)
      $display("miller_rabin_prime_test regression: pass");
    else
      $display("miller_rabin_prime_test regression: fail");
    $finish;
  end

endmodule
